// ===== sv/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg - breakpoint address table shared definitions
// Field widths, operation codes, sequencer states and the result struct.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int DEF_TABLE_DEPTH = 8;
	localparam int DEF_ADDR_BITS   = 32;

	localparam int OP_W      = 2;
	localparam int IN_ADDR_W = 32;
	localparam int POS_W     = 8;
	localparam int CNT_OUT_W = 4;

	localparam int IN_DATA_W  = 48;  // op + addr + position, padded to bytes
	localparam int OUT_DATA_W = 8;   // ok + count, padded to a byte

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                 ok;
		logic [CNT_OUT_W-1:0] count;
	} result_t;

endpackage

// ===== sv/bat_mem.sv =====
// ----------------------------------------------------------------------------
// bat_mem - entry storage
// One write port, one read port, registered read data. No reset of contents.
// ----------------------------------------------------------------------------
module bat_mem #(
	parameter int DEPTH  = 8,
	parameter int DATA_W = 32,
	parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/bat_ctrl.sv =====
// ----------------------------------------------------------------------------
// bat_ctrl - operation sequencer
// Walks the table one entry at a time through a single comparator for set and
// query, and moves entries down one place, a read then a write each, for clear.
// ----------------------------------------------------------------------------
module bat_ctrl #(
	parameter int TABLE_DEPTH = 8,
	parameter int ADDR_BITS   = 32,
	parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bat_pkg::OP_W-1:0]        in_op,
	input  logic [bat_pkg::IN_ADDR_W-1:0]   in_addr,
	input  logic [bat_pkg::POS_W-1:0]       in_pos,
	output logic                            res_valid,
	input  logic                            res_ready,
	output bat_pkg::result_t                res,
	output logic                            mem_we,
	output logic [IDX_W-1:0]                mem_waddr,
	output logic [ADDR_BITS-1:0]            mem_wdata,
	output logic                            mem_re,
	output logic [IDX_W-1:0]                mem_raddr,
	input  logic [ADDR_BITS-1:0]            mem_rdata
);

	import bat_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t         state_q, state_d;
	op_t            op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [CW-1:0]  idx_q, idx_d;
	logic [CW-1:0]  count_q, count_d;
	logic           ok_q, ok_d;
	logic [CW:0]    idx_nxt;
	logic           accept;

	assign accept  = in_valid && in_ready;
	assign idx_nxt = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(in_op);
			addr_q <= ADDR_BITS'(in_addr);
		end
		idx_q <= idx_d;
		ok_q  <= ok_d;
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		ok_d      = ok_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = addr_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ok_d  = 1'b0;
					idx_d = '0;
					case (in_op)
						OP_SET, OP_QUERY: state_d = ST_SRCH_RD;
						OP_CLEAR: begin
							if (in_pos != '0 && in_pos <= POS_W'(count_q)) begin
								idx_d   = CW'(in_pos - POS_W'(1));
								state_d = ST_SHIFT_RD;
							end else begin
								state_d = ST_RESP;
							end
						end
						default: state_d = ST_RESP;  // reserved op: no change
					endcase
				end
			end
			ST_SRCH_RD: begin
				if (idx_q == count_q) begin
					// miss: append on set if there is room
					if (op_q == OP_SET && count_q < CW'(TABLE_DEPTH)) begin
						mem_we  = 1'b1;
						count_d = count_q + CW'(1);
						ok_d    = 1'b1;
					end
					state_d = ST_RESP;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (mem_rdata == addr_q) begin
					ok_d    = 1'b1;
					state_d = ST_RESP;
				end else begin
					idx_d   = idx_nxt[CW-1:0];
					state_d = ST_SRCH_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (idx_nxt >= {1'b0, count_q}) begin
					count_d = count_q - CW'(1);
					ok_d    = 1'b1;
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_nxt[IDX_W-1:0];
					state_d   = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
				idx_d     = idx_nxt[CW-1:0];
				state_d   = ST_SHIFT_RD;
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res.ok    = ok_q;
	assign res.count = CNT_OUT_W'(count_q);

endmodule

// ===== sv/breakpoint_address_table_unit.sv =====
// ----------------------------------------------------------------------------
// breakpoint_address_table_unit - breakpoint address table
// Compact list of breakpoint addresses with set, clear-by-position and query.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   op[1:0], addr[33:2], position[41:34], zero pad to 48 bits
// m_axis    out  ok[0], count[4:1], zero pad to 8 bits
//
// Steps: the accept, then a registered memory read and a compare per entry for
// set/query (the single comparator checks one entry per read), or a read and
// a write per entry moved for clear, one more step to see the end of the list,
// then the handover of the result. A hit ends the scan early.
// The slowest transaction is a set missing a full table, which compares every entry;
// the result shows on m_tvalid the cycle after the handover.
// Reset clears the fill count, sequencer and output valid only; entry contents
// stay unknown and are never read before being written.
// A stalled m_axis holds its result; the next input is still accepted into
// the sequencer while the previous result waits in the output register.
//
module breakpoint_address_table_unit #(
	parameter int TABLE_DEPTH = bat_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_BITS   = bat_pkg::DEF_ADDR_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bat_pkg::IN_DATA_W-1:0]     s_tdata,   // op, addr, position
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bat_pkg::OUT_DATA_W-1:0]    m_tdata    // ok, count
);

	import bat_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// input field unpacking
	logic [OP_W-1:0]      in_op;
	logic [IN_ADDR_W-1:0] in_addr;
	logic [POS_W-1:0]     in_pos;

	assign in_op   = s_tdata[OP_W-1:0];
	assign in_addr = s_tdata[OP_W+IN_ADDR_W-1:OP_W];
	assign in_pos  = s_tdata[OP_W+IN_ADDR_W+POS_W-1:OP_W+IN_ADDR_W];

	// sequencer <-> storage
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [ADDR_BITS-1:0] mem_wdata, mem_rdata;

	// sequencer -> output register
	logic    res_valid, res_ready;
	result_t res;

	// output register
	logic    m_tvalid_q;
	result_t m_res_q;

	bat_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_BITS   (ADDR_BITS),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (in_op),
		.in_addr   (in_addr),
		.in_pos    (in_pos),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bat_mem #(
		.DEPTH  (TABLE_DEPTH),
		.DATA_W (ADDR_BITS),
		.IDX_W  (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result slot is free when empty or draining this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({m_res_q.count, m_res_q.ok});

endmodule

// ===== sv/bat_chk.sv =====
// ----------------------------------------------------------------------------
// bat_chk - port-level checks for the breakpoint address table
// Watches the stream ports and flags handshake and count violations.
// ----------------------------------------------------------------------------
module bat_chk #(
	parameter int TABLE_DEPTH = bat_pkg::DEF_TABLE_DEPTH
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bat_pkg::OUT_DATA_W-1:0] m_tdata
);

	import bat_pkg::*;

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// reported count never exceeds the table depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (TABLE_DEPTH > 15) ||
		(m_tdata[CNT_OUT_W:1] <= CNT_OUT_W'(TABLE_DEPTH)))
		else $error("count beyond table depth");

	// pad bits of a result are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:CNT_OUT_W+1] == '0)
		else $error("nonzero result padding");

endmodule

bind breakpoint_address_table_unit bat_chk #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_bat_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/breakpoint_address_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// breakpoint_address_table_unit_test - self-checking bench for the table
// Drives set, clear-by-position, query and undefined-op transactions, keeps
// its own copy of the table to predict ok/count for every transaction, and
// checks each output transaction in order under random idling on both sides.
// ----------------------------------------------------------------------------
module breakpoint_address_table_unit_test;
	import bat_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	// op code the block ignores; it still answers with ok=0 and the count
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
	// worst-case sequencer time per transaction plus some margin
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int TIMEOUT_CYCLES = 400_000;
	localparam int POOL_SIZE = 12;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // op, addr, position, zero pad
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // ok, count, zero pad

	// idle rates in percent, changed between phases
	int src_idle_pct  = 21;
	int sink_idle_pct = 59;
	int fail_count    = 0;

	// predicted table contents, mirrors what the block should hold
	logic [IN_ADDR_W-1:0] bp_table [DEPTH];
	int                   bp_count = 0;

	// ok/count status of every accepted transaction not yet answered
	result_t status_queue [$];

	// small address pool so that sets hit existing entries and fill the table
	logic [IN_ADDR_W-1:0] addr_pool [POOL_SIZE];

	breakpoint_address_table_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Apply one operation to the predicted table and return the status the
	// block must report. Only entries below the count are ever looked at.
	function automatic result_t table_apply(input logic [OP_W-1:0] op,
			input logic [IN_ADDR_W-1:0] addr, input logic [POS_W-1:0] pos);
		result_t r;
		bit      hit;
		r.ok = 1'b0;
		hit = 1'b0;
		for (int k = 0; k < bp_count; k++) begin
			if (bp_table[k] == addr)
				hit = 1'b1;
		end
		case (op)
			OP_SET: begin
				if (hit) begin
					r.ok = 1'b1;
				end else if (bp_count < DEPTH) begin
					bp_table[bp_count] = addr;
					bp_count++;
					r.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				// 1-based position; later entries move down one place
				if (pos != 0 && pos <= bp_count) begin
					for (int k = pos - 1; k < bp_count - 1; k++)
						bp_table[k] = bp_table[k + 1];
					bp_count--;
					r.ok = 1'b1;
				end
			end
			OP_QUERY: begin
				r.ok = hit;
			end
			default: begin
				// undefined op: table untouched, ok stays low
			end
		endcase
		r.count = bp_count[CNT_OUT_W-1:0];
		return r;
	endfunction

	// One input transaction: optional random gap, then hold tvalid until the
	// block takes it. tvalid stays high on return so back-to-back transactions
	// never drop it within a step.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_ADDR_W-1:0] addr,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W - OP_W - IN_ADDR_W - POS_W){1'b0}}, pos, addr, op};
		do @(posedge clk); while (!s_tready);
		status_queue.push_back(table_apply(op, addr, pos));
	endtask

	// Stop sending and let every outstanding transaction come back, then give
	// the sequencer its worst-case time to go idle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (status_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: every accepted transaction is matched against the oldest
	// prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (status_queue.size() == 0) begin
				$error("unexpected result transaction, m_tdata=%h", m_tdata);
				fail_count++;
			end else begin
				want = status_queue.pop_front();
				if (m_tdata[0] !== want.ok) begin
					$error("ok mismatch: expected %0d, actual %0d", want.ok, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[4:1] !== want.count) begin
					$error("count mismatch: expected %0d, actual %0d",
						want.count, m_tdata[4:1]);
					fail_count++;
				end
			end
		end
	end

	// Empty table: nothing matches, nothing can be cleared.
	task automatic test_empty_table();
		send_item(OP_QUERY, 32'h0000_0000, 8'd0);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd0);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 8'd1);
	endtask

	// Fill to capacity, including a duplicate set, then a set on a full table
	// (new address fails, present address still succeeds).
	task automatic test_fill_and_full();
		send_item(OP_SET, 32'h0000_0000, 8'd0);
		send_item(OP_SET, 32'hFFFF_FFFF, 8'd255);
		send_item(OP_SET, 32'hFFFF_FFFF, 8'd0);
		send_item(OP_SET, 32'hA5A5_A5A5, 8'd0);
		send_item(OP_SET, 32'h5A5A_5A5A, 8'd0);
		send_item(OP_SET, 32'h0000_0001, 8'd0);
		send_item(OP_SET, 32'h0000_0002, 8'd0);
		send_item(OP_SET, 32'h0000_0003, 8'd0);
		send_item(OP_SET, 32'h8000_0000, 8'd0);
		send_item(OP_SET, 32'h1234_5678, 8'd0);
		send_item(OP_SET, 32'h0000_0000, 8'd0);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 8'd0);
		send_item(OP_QUERY, 32'h1234_5678, 8'd0);
	endtask

	// Bad positions (beyond count, max, zero) then last, first and middle.
	task automatic test_clear_positions();
		send_item(OP_CLEAR, 32'h0000_0000, 8'd9);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd255);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd0);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd8);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd1);
		send_item(OP_CLEAR, 32'h0000_0000, 8'd3);
		// 5A5A5A5A was at 4, moved to 3 by the clear at 1, then removed
		send_item(OP_QUERY, 32'h5A5A_5A5A, 8'd0);
	endtask

	task automatic test_undefined_op();
		send_item(OP_UNDEF, $urandom, 8'($urandom));
		send_item(OP_UNDEF, 32'hFFFF_FFFF, 8'd255);
	endtask

	// Random mix weighted toward well-formed traffic: pool addresses and
	// stored addresses so sets hit and queries match, clear positions mostly
	// in the range 0 to DEPTH+1, with a tail of fully random fields.
	task automatic test_random(input int n_items);
		logic [OP_W-1:0]      op;
		logic [IN_ADDR_W-1:0] addr;
		logic [POS_W-1:0]     pos;
		int                   pick;
		int                   src;
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 38)
				op = OP_SET;
			else if (pick < 65)
				op = OP_CLEAR;
			else if (pick < 95)
				op = OP_QUERY;
			else
				op = OP_UNDEF;
			src = $urandom_range(9);
			if (src < 5)
				addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
			else if (src < 8 && bp_count > 0)
				addr = bp_table[$urandom_range(bp_count - 1)];
			else
				addr = $urandom;
			if ($urandom_range(9) < 8)
				pos = 8'($urandom_range(DEPTH + 1));
			else
				pos = 8'($urandom_range(255));
			send_item(op, addr, pos);
		end
	endtask

	initial begin
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < POOL_SIZE; k++)
			addr_pool[k] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_full();
		// hold off until the whole directed burst has been answered
		wait_idle();
		test_clear_positions();
		test_undefined_op();
		wait_idle();

		test_random(500);
		wait_idle();

		src_idle_pct  = 59;
		sink_idle_pct = 21;
		test_random(500);
		wait_idle();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random(500);
		wait_idle();

		if (fail_count == 0 && status_queue.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard: well beyond the slowest legal run
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
